// File: rtl/rse_pkg.sv
// rse_pkg: shared constants, types and helper function of the shuffle engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package rse_pkg;

    localparam int MAX_WORDS  = 64;
    localparam int WORD_IDX_W = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);

    localparam int MT_N     = 624;
    localparam int MT_M     = 397;
    localparam int MT_IDX_W = $clog2(MT_N + 1);

    localparam logic [31:0] MT_SEED_MULT = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX_A  = 32'h9908_b0df;
    localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMPER_C  = 32'hefc6_0000;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SEED,
        S_DRAW_REQ,
        S_DRAW,
        S_DIV,
        S_RD_J,
        S_RD_K,
        S_WR_J,
        S_WR_K,
        S_EMIT_RD,
        S_EMIT
    } t_rse_state;

    typedef enum logic [3:0] {
        MT_IDLE,
        MT_SEED_MUL,
        MT_SEED_WR,
        MT_TW_RD0,
        MT_TW_RD1,
        MT_TW_RD2,
        MT_TW_WR,
        MT_DRAW_RD,
        MT_DRAW_OUT
    } t_mt_state;

    typedef struct packed {
        logic reseed;
        logic draw;
    } t_mt_ctl;

    typedef struct packed {
        logic done;
    } t_mt_sts;

    function automatic logic [31:0] mt_temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage
`default_nettype wire

// File: rtl/rse_in_if.sv
// rse_in_if: input channel of the shuffle engine, one word per beat
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface rse_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] element;
    logic        final_element;
    modport source (output valid, output element, output final_element, input ready);
    modport sink   (input valid, input element, input final_element, output ready);
endinterface
`default_nettype wire

// File: rtl/rse_out_if.sv
// rse_out_if: result channel of the shuffle engine, one permuted word per beat
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface rse_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] shuffled_word;
    logic        end_of_run;
    modport source (output valid, output shuffled_word, output end_of_run, input ready);
    modport sink   (input valid, input shuffled_word, input end_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/rse_cfg_if.sv
// rse_cfg_if: seed register write channel
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface rse_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rse_divider.sv
// rse_divider: bit-serial restoring remainder of a 32-bit draw by a small modulus
// depends on rse_pkg
`timescale 1ns / 1ps
`default_nettype none
module rse_divider
    import rse_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [CNT_W-1:0]      o_rem
);

    logic             r_busy, n_busy;
    logic [4:0]       r_cnt, n_cnt;
    logic [31:0]      r_quo, n_quo;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_div, n_div;
    logic             r_done, n_done;
    logic [CNT_W:0]   trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[31]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // one quotient bit a cycle
            if (trial >= {1'b0, r_div}) begin
                n_rem = CNT_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = CNT_W'(trial);
            end
            n_quo = {r_quo[30:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// File: rtl/rse_twister.sv
// rse_twister: mt19937 generator with its state in a single-port-read memory
// depends on rse_pkg
`timescale 1ns / 1ps
`default_nettype none
module rse_twister
    import rse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_mt_ctl     i_ctl,
    input  wire logic [31:0] i_seed,
    output t_mt_sts          o_sts,
    output logic [31:0]      o_draw
);

    logic [31:0] mem [MT_N];
    logic [31:0] r_rd_data;

    t_mt_state            r_state, n_state;
    logic [MT_IDX_W-1:0]  r_idx, n_idx;
    logic [MT_IDX_W-1:0]  r_i, n_i;
    logic [31:0]          r_prev, n_prev;
    logic [31:0]          r_prod, n_prod;
    logic [31:0]          r_a, n_a;
    logic [31:0]          r_b, n_b;

    logic                 rd_en;
    logic [MT_IDX_W-1:0]  rd_addr;
    logic                 wr_en;
    logic [MT_IDX_W-1:0]  wr_addr;
    logic [31:0]          wr_data;
    logic [MT_IDX_W:0]    far_sum;
    logic [31:0]          y;
    logic [31:0]          seed_val;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MT_IDLE;
            r_idx   <= MT_IDX_W'(MT_N);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_i    <= n_i;
        r_prev <= n_prev;
        r_prod <= n_prod;
        r_a    <= n_a;
        r_b    <= n_b;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_i      = r_i;
        n_prev   = r_prev;
        n_prod   = r_prod;
        n_a      = r_a;
        n_b      = r_b;
        rd_en    = 1'b0;
        rd_addr  = r_i;
        wr_en    = 1'b0;
        wr_addr  = r_i;
        wr_data  = '0;
        o_sts    = '0;
        far_sum  = {1'b0, r_i} + (MT_IDX_W + 1)'(MT_M);
        y        = {r_a[31], r_b[30:0]};
        seed_val = r_prod + 32'(r_i);
        unique case (r_state)
            MT_IDLE: begin
                if (i_ctl.reseed) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = i_seed;
                    n_prev  = i_seed;
                    n_i     = MT_IDX_W'(1);
                    n_state = MT_SEED_MUL;
                end else if (i_ctl.draw) begin
                    if (r_idx == MT_IDX_W'(MT_N)) begin
                        n_i     = '0;
                        n_state = MT_TW_RD0;
                    end else begin
                        n_state = MT_DRAW_RD;
                    end
                end
            end
            MT_SEED_MUL: begin
                n_prod  = 32'(MT_SEED_MULT * (r_prev ^ (r_prev >> 30)));
                n_state = MT_SEED_WR;
            end
            MT_SEED_WR: begin
                wr_en   = 1'b1;
                wr_data = seed_val;
                n_prev  = seed_val;
                if (r_i == MT_IDX_W'(MT_N - 1)) begin
                    n_idx     = MT_IDX_W'(MT_N);
                    o_sts.done = 1'b1;
                    n_state   = MT_IDLE;
                end else begin
                    n_i     = r_i + MT_IDX_W'(1);
                    n_state = MT_SEED_MUL;
                end
            end
            MT_TW_RD0: begin
                rd_en   = 1'b1;
                n_state = MT_TW_RD1;
            end
            MT_TW_RD1: begin
                n_a     = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = (r_i == MT_IDX_W'(MT_N - 1)) ? '0 : r_i + MT_IDX_W'(1);
                n_state = MT_TW_RD2;
            end
            MT_TW_RD2: begin
                n_b     = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = (far_sum >= (MT_IDX_W + 1)'(MT_N))
                        ? MT_IDX_W'(far_sum - (MT_IDX_W + 1)'(MT_N))
                        : MT_IDX_W'(far_sum);
                n_state = MT_TW_WR;
            end
            MT_TW_WR: begin
                wr_en   = 1'b1;
                wr_data = r_rd_data ^ (y >> 1) ^ (y[0] ? MT_MATRIX_A : 32'd0);
                if (r_i == MT_IDX_W'(MT_N - 1)) begin
                    n_idx   = '0;
                    n_state = MT_DRAW_RD;
                end else begin
                    n_i     = r_i + MT_IDX_W'(1);
                    n_state = MT_TW_RD0;
                end
            end
            MT_DRAW_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_idx   = r_idx + MT_IDX_W'(1);
                n_state = MT_DRAW_OUT;
            end
            MT_DRAW_OUT: begin
                o_sts.done = 1'b1;
                n_state    = MT_IDLE;
            end
            default: begin
                n_state = MT_IDLE;
            end
        endcase
    end

    assign o_draw = mt_temper(r_rd_data);

endmodule
`default_nettype wire

// File: rtl/random_shuffle_engine.sv
// random_shuffle_engine: top level, word store, load/shuffle/emit sequencer
// depends on rse_pkg, rse_in_if, rse_out_if, rse_cfg_if, rse_twister, rse_divider
`timescale 1ns / 1ps
`default_nettype none
// Collects up to MAX_WORDS 64-bit words, one per input beat, the beat with
// final_element set closing the set (words beyond MAX_WORDS are dropped), then
// shuffles them with Fisher-Yates driven by an MT19937 generator reseeded from
// the seed register at every run, and emits the permuted words in index order
// with end_of_run on the last. The input is ready throughout loading. After the
// final word the input is not ready until the last result beat is taken: seeding
// the 624-word generator state takes a multiply state and a write state per
// entry, the first draw of a run adds a full twist that reads three state words
// through the one memory read port and writes one per entry, and each shuffle
// step then fetches a draw from the generator, reduces it with the bit-serial
// remainder and swaps two words through the word store's one read port.
// Emitting takes a read state and an output state per word. A set of one word
// skips seeding and is emitted right away.
module random_shuffle_engine
    import rse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rse_in_if.sink    i_in,
    rse_out_if.source o_out,
    rse_cfg_if.sink   i_cfg
);

    // word store, registered read
    logic [63:0] mem [MAX_WORDS];
    logic [63:0] r_rd_word;
    logic                  ws_rd_en;
    logic [WORD_IDX_W-1:0] ws_rd_addr;
    logic                  ws_wr_en;
    logic [WORD_IDX_W-1:0] ws_wr_addr;
    logic [63:0]           ws_wr_data;

    t_rse_state            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_n, n_n;
    logic [WORD_IDX_W-1:0] r_j, n_j;
    logic [WORD_IDX_W-1:0] r_k, n_k;
    logic [WORD_IDX_W-1:0] r_e, n_e;
    logic [31:0]           r_draw, n_draw;
    logic [63:0]           r_wj, n_wj;
    logic [31:0]           r_seed;

    t_mt_ctl               mt_ctl;
    t_mt_sts               mt_sts;
    logic [31:0]           mt_draw;
    logic                  div_start;
    logic                  div_done;
    logic [CNT_W-1:0]      div_rem;
    logic [CNT_W-1:0]      modulus;
    logic [32:0]           span_end;
    logic                  in_beat;
    logic [CNT_W-1:0]      load_count;
    logic                  last_word;

    rse_twister u_twister (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mt_ctl),
        .i_seed  (r_seed),
        .o_sts   (mt_sts),
        .o_draw  (mt_draw)
    );

    rse_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mt_draw),
        .i_divisor  (modulus),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (ws_wr_en) begin
            mem[ws_wr_addr] <= ws_wr_data;
        end
        if (ws_rd_en) begin
            r_rd_word <= mem[ws_rd_addr];
        end
    end

    // seed register, always writable
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd5489;
        end else if (i_cfg.valid) begin
            r_seed <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_n    <= n_n;
        r_j    <= n_j;
        r_k    <= n_k;
        r_e    <= n_e;
        r_draw <= n_draw;
        r_wj   <= n_wj;
    end

    assign modulus    = {1'b0, r_j} + CNT_W'(1);
    assign in_beat    = i_in.valid && i_in.ready;
    assign load_count = (r_count < CNT_W'(MAX_WORDS)) ? r_count + CNT_W'(1) : r_count;
    // draw is rejected when the start of its bucket plus the modulus reaches 2^32
    assign span_end   = {1'b0, r_draw} - {{(33 - CNT_W){1'b0}}, div_rem}
                      + {{(33 - CNT_W){1'b0}}, modulus};
    assign last_word  = ({1'b0, r_e} + CNT_W'(1)) == r_n;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_j        = r_j;
        n_k        = r_k;
        n_e        = r_e;
        n_draw     = r_draw;
        n_wj       = r_wj;
        mt_ctl     = '0;
        div_start  = 1'b0;
        ws_rd_en   = 1'b0;
        ws_rd_addr = r_j;
        ws_wr_en   = 1'b0;
        ws_wr_addr = r_j;
        ws_wr_data = r_rd_word;
        i_in.ready = 1'b0;
        o_out.valid         = 1'b0;
        o_out.shuffled_word = r_rd_word;
        o_out.end_of_run    = last_word;
        unique case (r_state)
            S_LOAD: begin
                i_in.ready = 1'b1;
                if (in_beat) begin
                    if (r_count < CNT_W'(MAX_WORDS)) begin
                        ws_wr_en   = 1'b1;
                        ws_wr_addr = WORD_IDX_W'(r_count);
                        ws_wr_data = i_in.element;
                    end
                    n_count = load_count;
                    if (i_in.final_element) begin
                        n_n = load_count;
                        n_j = WORD_IDX_W'(load_count - CNT_W'(1));
                        n_e = '0;
                        if (load_count == CNT_W'(1)) begin
                            n_state = S_EMIT_RD;
                        end else begin
                            mt_ctl.reseed = 1'b1;
                            n_state       = S_SEED;
                        end
                    end
                end
            end
            S_SEED: begin
                // the generator is back in idle only on the cycle after done
                if (mt_sts.done) begin
                    n_state = S_DRAW_REQ;
                end
            end
            S_DRAW_REQ: begin
                mt_ctl.draw = 1'b1;
                n_state     = S_DRAW;
            end
            S_DRAW: begin
                if (mt_sts.done) begin
                    n_draw    = mt_draw;
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (span_end[32]) begin
                        mt_ctl.draw = 1'b1;
                        n_state     = S_DRAW;
                    end else begin
                        n_k     = WORD_IDX_W'(div_rem);
                        n_state = S_RD_J;
                    end
                end
            end
            S_RD_J: begin
                ws_rd_en = 1'b1;
                n_state  = S_RD_K;
            end
            S_RD_K: begin
                n_wj       = r_rd_word;
                ws_rd_en   = 1'b1;
                ws_rd_addr = r_k;
                n_state    = S_WR_J;
            end
            S_WR_J: begin
                ws_wr_en = 1'b1;
                n_state  = S_WR_K;
            end
            S_WR_K: begin
                ws_wr_en   = 1'b1;
                ws_wr_addr = r_k;
                ws_wr_data = r_wj;
                if (r_j == WORD_IDX_W'(1)) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_j         = r_j - WORD_IDX_W'(1);
                    mt_ctl.draw = 1'b1;
                    n_state     = S_DRAW;
                end
            end
            S_EMIT_RD: begin
                ws_rd_en   = 1'b1;
                ws_rd_addr = r_e;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    if (last_word) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_e     = r_e + WORD_IDX_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: bench/tb_random_shuffle_engine.sv
// tb_random_shuffle_engine: self-checking bench for the word shuffle engine
// depends on rse_pkg, rse_in_if, rse_out_if, rse_cfg_if and random_shuffle_engine
`timescale 1ns / 1ps
module tb_random_shuffle_engine;
    import rse_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 12000000;
    localparam int SETTLE      = 40;
    localparam int TARGET      = 500;

    // one permuted word as the block should emit it
    typedef struct {
        logic [63:0] word;
        logic        last;
    } t_perm_beat;

    // one row of the directed table; typed rows carry their own expected beat
    typedef struct {
        logic [63:0] word;
        logic        last;
        logic        typed;
        logic [63:0] exp_word;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    rse_in_if  in_ch ();
    rse_out_if out_ch ();
    rse_cfg_if cfg_ch ();

    random_shuffle_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // ---------------------------------------------------------------
    // shadow state of the engine: word set, generator, seed register
    // ---------------------------------------------------------------
    logic [63:0] held_words [MAX_WORDS];
    int          held_count;
    logic [31:0] twister [MT_N];
    int          twister_pos;
    logic [31:0] seed_reg;

    t_perm_beat  perm_q [$];     // permuted words still owed by the block
    int          err_count;
    int          beats_sent;
    int          runs_done;
    int          words_checked;
    int          hold_off;       // receiver long hold-off, in cycles
    logic        busy_sender;    // sender idles at random when set
    longint      cycle_count;

    // generator seeding, full twist and one tempered draw
    function automatic void twister_seed(input logic [31:0] s);
        twister[0] = s;
        for (int i = 1; i < MT_N; i++)
            twister[i] = 32'd1812433253 * (twister[i-1] ^ (twister[i-1] >> 30)) + 32'(i);
        twister_pos = MT_N;
    endfunction

    function automatic void twister_twist();
        logic [31:0] y;
        logic [31:0] v;
        for (int i = 0; i < MT_N; i++) begin
            y = (twister[i] & 32'h8000_0000) | (twister[(i + 1) % MT_N] & 32'h7fff_ffff);
            v = twister[(i + MT_M) % MT_N] ^ (y >> 1);
            if (y[0])
                v = v ^ 32'h9908_b0df;
            twister[i] = v;
        end
        twister_pos = 0;
    endfunction

    function automatic logic [31:0] twister_draw();
        logic [31:0] y;
        if (twister_pos >= MT_N)
            twister_twist();
        y = twister[twister_pos];
        twister_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // take one accepted beat; on the closing beat, shuffle and return the run
    function automatic void absorb_word(input logic [63:0] w, input logic fin,
                                        ref t_perm_beat run_q [$]);
        logic [31:0] span;
        logic [31:0] ceiling;
        logic [31:0] pick;
        logic [63:0] tmp;
        run_q.delete();
        // words past a full store are dropped, closing word included
        if (held_count < MAX_WORDS) begin
            held_words[held_count] = w;
            held_count++;
        end
        if (!fin)
            return;
        twister_seed(seed_reg);
        for (int j = held_count - 1; j >= 1; j--) begin
            span    = 32'(j + 1);
            ceiling = 32'hffff_ffff - (32'hffff_ffff % span);
            // rejection keeps the index draw unbiased
            do pick = twister_draw(); while (pick >= ceiling);
            pick          = pick % span;
            tmp           = held_words[j];
            held_words[j] = held_words[pick];
            held_words[pick] = tmp;
        end
        for (int j = 0; j < held_count; j++)
            run_q.push_back('{word: held_words[j], last: (j == held_count - 1)});
        held_count = 0;
    endfunction

    // ---------------------------------------------------------------
    // clock, reset, watchdog
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d words still owed",
                         cycle_count, perm_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // result side: random backpressure, long hold-off on request, check
    // ---------------------------------------------------------------
    initial begin
        int         gap;
        t_perm_beat want;
        out_ch.ready <= 1'b0;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (perm_q.size() == 0) begin
                    $error("unexpected beat: shuffled_word %h end_of_run %b",
                           out_ch.shuffled_word, out_ch.end_of_run);
                    err_count++;
                end else begin
                    want = perm_q.pop_front();
                    words_checked++;
                    if (out_ch.shuffled_word !== want.word) begin
                        $error("shuffled_word: expected %h actual %h",
                               want.word, out_ch.shuffled_word);
                        err_count++;
                    end
                    if (out_ch.end_of_run !== want.last) begin
                        $error("end_of_run: expected %b actual %b",
                               want.last, out_ch.end_of_run);
                        err_count++;
                    end
                end
            end
            // the long hold-off is counted here so the sender keeps pushing
            if (hold_off > 0) begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                out_ch.ready <= 1'b0;
            end else begin
                gap = pick_gap();
                out_ch.ready <= (gap == 0);
            end
        end
    end

    // ---------------------------------------------------------------
    // input side helpers
    // ---------------------------------------------------------------

    // offer one beat; valid stays high afterwards unless the next beat idles
    task automatic send_word(input logic [63:0] w, input logic fin,
                             input logic typed, input logic [63:0] exp_word);
        int         gap;
        t_perm_beat run_q [$];
        gap = busy_sender ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.element       <= w;
        in_ch.final_element <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        beats_sent++;
        absorb_word(w, fin, run_q);
        if (fin)
            runs_done++;
        // typed rows are single-word sets: the word comes straight back
        if (typed)
            perm_q.push_back('{word: exp_word, last: 1'b1});
        else
            foreach (run_q[i])
                perm_q.push_back(run_q[i]);
    endtask

    // one set of random words, the last beat closing it
    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_word({$urandom, $urandom}, (i == n - 1), 1'b0, '0);
    endtask

    // seed writes happen only with the engine drained and settled
    task automatic write_seed(input logic [31:0] s);
        in_ch.valid <= 1'b0;
        wait (perm_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= s;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        seed_reg = s;
    endtask

    // directed rows: extremes, single-word sets, small sets
    t_dir_row dir_rows [] = '{
        '{64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'hffff_ffff_ffff_ffff},
        '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
        '{64'h8000_0000_0000_0001, 1'b1, 1'b1, 64'h8000_0000_0000_0001},
        '{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0000_0000, 1'b1, 1'b0, '0},
        '{64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, '0},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, '0},
        '{64'h0123_4567_89ab_cdef, 1'b1, 1'b0, '0},
        '{64'h0000_0000_0000_0001, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0000_0002, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0000_0003, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0000_0004, 1'b0, 1'b0, '0},
        '{64'h0000_0000_0000_0005, 1'b1, 1'b0, '0}
    };

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        logic [31:0] seed_plan [$];
        int          sz;
        int          r;
        int          phase_end;

        err_count     = 0;
        beats_sent    = 0;
        runs_done     = 0;
        words_checked = 0;
        hold_off      = 0;
        busy_sender   = 1'b1;
        held_count    = 0;
        seed_reg      = 32'd5489;
        twister_seed(seed_reg);

        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.element       <= '0;
        in_ch.final_element <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs on the reset seed
        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].exp_word);

        // seed extremes and the reset value again first, then random seeds
        seed_plan = '{32'h0000_0000, 32'hffff_ffff, 32'd5489};
        repeat (7) seed_plan.push_back($urandom);

        foreach (seed_plan[p]) begin
            write_seed(seed_plan[p]);
            busy_sender = ($urandom_range(0, 3) != 0);
            phase_end   = beats_sent + TARGET / seed_plan.size();

            // stall the result side long enough for the store to back up
            if (p == 1) begin
                hold_off = 3000;
                send_set(20);
                send_set(6);
            end
            // a full store and an overflowing set on two of the phases
            if (p == 2)
                send_set(MAX_WORDS);
            if (p == 4)
                send_set(MAX_WORDS + $urandom_range(1, 5));

            while (beats_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    sz = 1;
                else if (r < 85)
                    sz = $urandom_range(2, 8);
                else if (r < 97)
                    sz = $urandom_range(9, 32);
                else
                    sz = $urandom_range(33, MAX_WORDS);
                send_set(sz);
            end
        end

        in_ch.valid <= 1'b0;
        wait (perm_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d input beats in %0d shuffle runs over %0d seeds",
                 beats_sent, runs_done, seed_plan.size() + 1);
        $display("checked %0d permuted words, %0d mismatches", words_checked, err_count);
        if (err_count == 0 && perm_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/rse_pkg.sv
rtl/rse_in_if.sv
rtl/rse_out_if.sv
rtl/rse_cfg_if.sv
rtl/rse_divider.sv
rtl/rse_twister.sv
rtl/random_shuffle_engine.sv
bench/tb_random_shuffle_engine.sv
